// ===== sv/tagged_message_mailbox_core_assert.svh =====
// Assertion macros for the mailbox core
`ifndef TAGGED_MESSAGE_MAILBOX_CORE_ASSERT_SVH
`define TAGGED_MESSAGE_MAILBOX_CORE_ASSERT_SVH

// same-cycle implication
`define TMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox assertion failed");

// next-cycle implication
`define TMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox assertion failed");

`endif

// ===== sv/tmm_pkg.sv =====
package tmm_pkg;

    localparam int DEF_NUM_RECEIVERS = 16;
    localparam int DEF_NUM_SLOTS     = 64;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_RECV  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NEXTX = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BUF_SMALL = 3'd4;

    localparam logic [1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd1;
    localparam logic [1:0] CFG_HDR_BYTES = 2'd2;
    localparam logic [1:0] CFG_FIRST_TX  = 2'd3;

endpackage

// ===== sv/tagged_message_mailbox_core.sv =====
// Send and next-id register their result on acceptance; receive passes through
// S_RD and S_CHK for each descriptor walked, flush through S_FRD and S_FCHK for
// each queued descriptor; receive or flush of an empty queue registers its result
// on acceptance. The walk follows the registered descriptor read (read, then check).
// Throughput: one item at a time; next item taken once the result beat leaves.
// Reset (synchronous, active low): all slots free, all queues empty, id count zero,
// registers at defaults; descriptor memories are not cleared.
module tagged_message_mailbox_core #(
    parameter int NUM_RECEIVERS = tmm_pkg::DEF_NUM_RECEIVERS,
    parameter int NUM_SLOTS     = tmm_pkg::DEF_NUM_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_sender_id,
    input  logic [3:0]  i_receiver_index,
    input  logic [15:0] i_message_length,
    input  logic [31:0] i_transaction,
    input  logic [31:0] i_payload_ref,
    input  logic [31:0] i_buffer_size,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_msg_sender,
    output logic [15:0] o_msg_length,
    output logic [31:0] o_msg_transaction,
    output logic [31:0] o_msg_payload_ref,
    output logic [31:0] o_new_transaction
);
    import tmm_pkg::*;
    `include "tagged_message_mailbox_core_assert.svh"

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (NUM_RECEIVERS > 1) ? $clog2(NUM_RECEIVERS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_FRD, S_FCHK} t_state;

    // config registers
    logic [15:0] r_max_len;
    logic [19:0] r_max_bytes;
    logic [7:0]  r_hdr;
    logic [31:0] r_first_tx;

    // descriptor memories
    logic [15:0]   m_sender [NUM_SLOTS];
    logic [15:0]   m_length [NUM_SLOTS];
    logic [31:0]   m_tx     [NUM_SLOTS];
    logic [31:0]   m_payload[NUM_SLOTS];
    logic [SW-1:0] m_next   [NUM_SLOTS];
    logic [SW-1:0] m_prev   [NUM_SLOTS];

    logic [15:0]   r_rd_sender, r_rd_length;
    logic [31:0]   r_rd_tx, r_rd_payload;
    logic [SW-1:0] r_rd_next, r_rd_prev;

    // queue state
    logic [NUM_SLOTS-1:0] r_free;
    logic [SW-1:0] r_head [NUM_RECEIVERS];
    logic [SW-1:0] r_tail [NUM_RECEIVERS];
    logic [NUM_RECEIVERS-1:0] r_used;
    logic [20:0]   r_bytes[NUM_RECEIVERS];
    logic [31:0]   r_tx_count;

    // walk context
    t_state        r_state;
    logic [SW-1:0] r_cur;
    logic [QW-1:0] r_q;
    logic [31:0]   r_tag;
    logic [31:0]   r_buf;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [15:0] r_o_sender, r_o_length;
    logic [31:0] r_o_tx, r_o_payload, r_o_new_tx;

    logic          w_in_acc;
    logic [QW-1:0] w_q;
    logic          w_q_ok;
    logic [21:0]   w_send_total;
    logic [NUM_SLOTS-1:0] w_free_1h;
    logic [SW-1:0] w_free_idx;
    logic          w_any_free;
    logic          w_send_ok;
    logic          w_match;
    logic [16:0]   w_cost;
    logic          w_too_small;
    logic          w_mid_unlink;

    logic          w_slot_we, w_next_we, w_prev_we;
    logic [SW-1:0] w_slot_wa, w_next_wa, w_prev_wa;
    logic [SW-1:0] w_next_wd, w_prev_wd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign w_in_acc    = i_valid && o_ready;
    assign w_q         = QW'(i_receiver_index);
    assign w_q_ok      = 32'(i_receiver_index) < NUM_RECEIVERS;

    // lowest free slot: isolate lowest set bit, then OR-encode
    assign w_free_1h  = r_free & (~r_free + NUM_SLOTS'(1));
    assign w_any_free = |r_free;
    always_comb begin
        w_free_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_free_1h[i]) begin
                w_free_idx = w_free_idx | SW'(i);
            end
        end
    end

    assign w_send_total = 22'(r_bytes[w_q]) + 22'(r_hdr) + 22'(i_message_length);
    assign w_send_ok    = (i_message_length <= r_max_len) && w_q_ok
                          && (w_send_total <= 22'(r_max_bytes)) && w_any_free;

    // receive check on the slot just read
    assign w_match      = (r_tag == 32'd0) || (r_rd_tx == r_tag);
    assign w_cost       = 17'(r_hdr) + 17'(r_rd_length);
    assign w_too_small  = 32'(w_cost) > r_buf;
    assign w_mid_unlink = (r_state == S_CHK) && w_match && !w_too_small
                          && (r_cur != r_head[r_q]) && (r_cur != r_tail[r_q]);

    // memory write ports
    always_comb begin
        w_slot_we = w_in_acc && (t_op'(i_operation) == OP_SEND) && w_send_ok;
        w_slot_wa = w_free_idx;
        w_next_we = w_slot_we && r_used[w_q];
        w_next_wa = r_tail[w_q];
        w_next_wd = w_free_idx;
        w_prev_we = w_slot_we;
        w_prev_wa = w_free_idx;
        w_prev_wd = r_tail[w_q];
        if (w_mid_unlink) begin
            w_next_we = 1'b1;
            w_next_wa = r_rd_prev;
            w_next_wd = r_rd_next;
            w_prev_we = 1'b1;
            w_prev_wa = r_rd_next;
            w_prev_wd = r_rd_prev;
        end
    end

    // descriptor memories: each with one write port and one registered read
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            m_sender[w_slot_wa]  <= i_sender_id;
            m_length[w_slot_wa]  <= i_message_length;
            m_tx[w_slot_wa]      <= i_transaction;
            m_payload[w_slot_wa] <= i_payload_ref;
        end
        if (w_next_we) begin
            m_next[w_next_wa] <= w_next_wd;
        end
        if (w_prev_we) begin
            m_prev[w_prev_wa] <= w_prev_wd;
        end
        if (r_state == S_RD || r_state == S_FRD) begin
            r_rd_sender  <= m_sender[r_cur];
            r_rd_length  <= m_length[r_cur];
            r_rd_tx      <= m_tx[r_cur];
            r_rd_payload <= m_payload[r_cur];
            r_rd_next    <= m_next[r_cur];
            r_rd_prev    <= m_prev[r_cur];
        end
    end

    // config, control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= 16'd8192;
            r_max_bytes <= 20'd65536;
            r_hdr       <= 8'd16;
            r_first_tx  <= 32'd1;
            r_free      <= '1;
            r_used      <= '0;
            r_tx_count  <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_RECEIVERS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_bytes[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_LEN:   r_max_len   <= i_cfg_data[15:0];
                    CFG_MAX_BYTES: r_max_bytes <= i_cfg_data[19:0];
                    CFG_HDR_BYTES: r_hdr       <= i_cfg_data[7:0];
                    CFG_FIRST_TX:  r_first_tx  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_q         <= w_q;
                        r_tag       <= i_transaction;
                        r_buf       <= i_buffer_size;
                        r_cur       <= r_head[w_q];
                        r_status    <= ST_OK;
                        r_o_sender  <= '0;
                        r_o_length  <= '0;
                        r_o_tx      <= '0;
                        r_o_payload <= '0;
                        r_o_new_tx  <= '0;
                        case (t_op'(i_operation))
                            OP_SEND: begin
                                r_out_valid <= 1'b1;
                                if (i_message_length > r_max_len) begin
                                    r_status <= ST_TOO_LONG;
                                end else if (!w_send_ok) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_free[w_free_idx] <= 1'b0;
                                    r_bytes[w_q] <= w_send_total[20:0];
                                    r_tail[w_q]  <= w_free_idx;
                                    if (!r_used[w_q]) begin
                                        r_head[w_q] <= w_free_idx;
                                        r_used[w_q] <= 1'b1;
                                    end
                                end
                            end
                            OP_RECV: begin
                                if (w_q_ok && r_used[w_q]) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_status    <= ST_EMPTY;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            OP_FLUSH: begin
                                if (w_q_ok && r_used[w_q]) begin
                                    r_state <= S_FRD;
                                end else begin
                                    if (w_q_ok) begin
                                        r_bytes[w_q] <= '0;
                                    end
                                    r_out_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_o_new_tx  <= r_first_tx + r_tx_count;
                                r_tx_count  <= r_tx_count + 32'd1;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_match) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (w_too_small) begin
                            r_status <= ST_BUF_SMALL;
                        end else begin
                            r_o_sender  <= r_rd_sender;
                            r_o_length  <= r_rd_length;
                            r_o_tx      <= r_rd_tx;
                            r_o_payload <= r_rd_payload;
                            r_free[r_cur] <= 1'b1;
                            r_bytes[r_q] <= (r_bytes[r_q] > 21'(w_cost))
                                            ? r_bytes[r_q] - 21'(w_cost) : '0;
                            if (r_cur == r_head[r_q] && r_cur == r_tail[r_q]) begin
                                r_used[r_q] <= 1'b0;
                            end else if (r_cur == r_head[r_q]) begin
                                r_head[r_q] <= r_rd_next;
                            end else if (r_cur == r_tail[r_q]) begin
                                r_tail[r_q] <= r_rd_prev;
                            end
                        end
                    end else if (r_cur == r_tail[r_q]) begin
                        r_state     <= S_IDLE;
                        r_status    <= ST_EMPTY;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_cur   <= r_rd_next;
                        r_state <= S_RD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    r_free[r_cur] <= 1'b1;
                    if (r_cur == r_tail[r_q]) begin
                        r_used[r_q]  <= 1'b0;
                        r_bytes[r_q] <= '0;
                        r_state      <= S_IDLE;
                        r_out_valid  <= 1'b1;
                    end else begin
                        r_cur   <= r_rd_next;
                        r_state <= S_FRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_msg_sender      = r_o_sender;
    assign o_msg_length      = r_o_length;
    assign o_msg_transaction = r_o_tx;
    assign o_msg_payload_ref = r_o_payload;
    assign o_new_transaction = r_o_new_tx;

    // an accepted beat is either still being worked on or has its result pending
    `TMM_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, w_in_acc, (r_state != S_IDLE) || r_out_valid)
    // a result is only shown once the walk is over
    `TMM_ASSERT_NOW(a_out_idle, i_clk, i_rst_n, r_out_valid, r_state == S_IDLE)
    // a walk only runs on a queue that holds descriptors
    `TMM_ASSERT_NOW(a_walk_used, i_clk, i_rst_n, (r_state == S_CHK) || (r_state == S_FCHK), r_used[r_q])

endmodule
